/* hw/rtl/adx_pkg.sv */
// ArtDmx deframer package: header layout constants, identifier table,
// status codes and the end-of-packet report type. No dependencies.
`default_nettype none

package adx_pkg;

    localparam int unsigned MAX_CHANNELS_DEF = 512;
    localparam int unsigned HEADER_LEN       = 18;
    localparam int unsigned COUNT_SAT        = 530;
    localparam int unsigned COUNT_W          = 10;
    localparam logic [15:0] OPCODE_DMX       = 16'h5000;

    localparam logic [COUNT_W-1:0] POS_OPC_LO = 10'd8;
    localparam logic [COUNT_W-1:0] POS_OPC_HI = 10'd9;
    localparam logic [COUNT_W-1:0] POS_UNI_LO = 10'd14;
    localparam logic [COUNT_W-1:0] POS_UNI_HI = 10'd15;
    localparam logic [COUNT_W-1:0] POS_LEN_HI = 10'd16;
    localparam logic [COUNT_W-1:0] POS_LEN_LO = 10'd17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_BAD_OP    = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [14:0] universe;
        logic [15:0] length;
    } t_done_info;

    // "Art-Net\0"
    function automatic logic [7:0] ident_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/adx_status.sv */
// ArtDmx end-of-packet status encoder: precedence of the error checks and
// masking of universe and length. Depends on adx_pkg.
`default_nettype none

module adx_status #(
    parameter int unsigned MaxChannels = adx_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic [adx_pkg::COUNT_W-1:0] i_total,
    input  wire logic                        i_id_mismatch,
    input  wire logic                        i_op_mismatch,
    input  wire logic [14:0]                 i_universe,
    input  wire logic [15:0]                 i_length,
    output adx_pkg::t_done_info              o_info
);

    logic        too_short;
    logic        too_large;
    logic        truncated;
    logic [16:0] needed;

    assign needed    = 17'(adx_pkg::HEADER_LEN) + {1'b0, i_length};
    assign too_short = i_total < adx_pkg::COUNT_W'(adx_pkg::HEADER_LEN);
    assign too_large = i_length > 16'(MaxChannels);
    assign truncated = {7'b0, i_total} < needed;

    always_comb begin
        o_info.universe = i_universe;
        o_info.length   = i_length;
        if (too_short) begin
            o_info.status   = adx_pkg::ST_SHORT;
            o_info.universe = '0;
            o_info.length   = '0;
        end else if (i_id_mismatch) begin
            o_info.status   = adx_pkg::ST_BAD_ID;
            o_info.universe = '0;
        end else if (i_op_mismatch) begin
            o_info.status   = adx_pkg::ST_BAD_OP;
            o_info.universe = '0;
        end else if (too_large) begin
            o_info.status   = adx_pkg::ST_TOO_LARGE;
        end else if (truncated) begin
            o_info.status   = adx_pkg::ST_TRUNC;
        end else begin
            o_info.status   = adx_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/artdmx_packet_deframer_core.sv */
// ArtDmx packet deframer top level: byte position tracking, header capture
// and the output register. Depends on adx_pkg and adx_status.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one packet byte per
//   transaction, i_last_byte marking the final byte. Output channel
//   (o_out_valid / i_out_stall) carries a transaction for every payload byte
//   within the declared length and below MaxChannels (o_has_byte) and for
//   every final byte (o_packet_done, with status, universe and length); both
//   may share one. Header bytes that are not final produce no output
//   transaction. An accepted byte's result is registered and shows in the next
//   cycle. Throughput is one byte per cycle while the receiver does not stall,
//   set by the single output register, reloaded in the cycle it is taken.
//   While the receiver stalls a held result, o_in_stall is raised and the
//   packet state stays put; nothing is dropped.
//   Reset clears the packet state and empties the output register.
//   The consumer discards streamed payload bytes unless the final status
//   is ok.
`default_nettype none

module artdmx_packet_deframer_core #(
    parameter int unsigned MaxChannels = adx_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_has_byte,
    output logic [7:0]       o_data_byte,
    output logic [8:0]       o_byte_index,
    output logic             o_packet_done,
    output logic [2:0]       o_status,
    output logic [14:0]      o_universe,
    output logic [15:0]      o_length
);

    localparam int unsigned CW = adx_pkg::COUNT_W;

    typedef logic [2:0] t_status_w;

    logic [CW-1:0] r_count,   n_count;
    logic          r_id_mis,  n_id_mis;
    logic [7:0]    r_op_low,  n_op_low;
    logic          r_op_mis,  n_op_mis;
    logic [14:0]   r_uni,     n_uni;
    logic [15:0]   r_len,     n_len;

    logic          r_out_valid;
    logic          r_has, r_done;
    logic [7:0]    r_data;
    logic [8:0]    r_idx;
    t_status_w     r_status;
    logic [14:0]   r_out_uni;
    logic [15:0]   r_out_len;

    logic          accept;
    logic          has;
    logic [CW-1:0] pay_idx;
    logic [CW-1:0] total;
    adx_pkg::t_done_info info;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign pay_idx    = r_count - CW'(adx_pkg::HEADER_LEN);
    assign total      = r_count + 1'b1;

    always_comb begin
        n_id_mis = r_id_mis;
        n_op_low = r_op_low;
        n_op_mis = r_op_mis;
        n_uni    = r_uni;
        n_len    = r_len;
        has      = 1'b0;
        if (r_count < CW'(8)) begin
            if (i_in_byte != adx_pkg::ident_byte(r_count[2:0])) begin
                n_id_mis = 1'b1;
            end
        end else if (r_count == adx_pkg::POS_OPC_LO) begin
            n_op_low = i_in_byte;
        end else if (r_count == adx_pkg::POS_OPC_HI) begin
            n_op_mis = {i_in_byte, r_op_low} != adx_pkg::OPCODE_DMX;
        end else if (r_count == adx_pkg::POS_UNI_LO) begin
            n_uni[7:0] = i_in_byte;
        end else if (r_count == adx_pkg::POS_UNI_HI) begin
            n_uni[14:8] = i_in_byte[6:0];
        end else if (r_count == adx_pkg::POS_LEN_HI) begin
            n_len[15:8] = i_in_byte;
        end else if (r_count == adx_pkg::POS_LEN_LO) begin
            n_len[7:0] = i_in_byte;
        end else begin
            has = ({6'b0, pay_idx} < r_len) && ({6'b0, pay_idx} < 16'(MaxChannels));
        end
        if (r_count < CW'(adx_pkg::COUNT_SAT)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    adx_status #(
        .MaxChannels (MaxChannels)
    ) u_status (
        .i_total       (total),
        .i_id_mismatch (n_id_mis),
        .i_op_mismatch (n_op_mis),
        .i_universe    (n_uni),
        .i_length      (n_len),
        .o_info        (info)
    );

    // packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_id_mis <= 1'b0;
            r_op_low <= '0;
            r_op_mis <= 1'b0;
            r_uni    <= '0;
            r_len    <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_count  <= '0;
                r_id_mis <= 1'b0;
                r_op_low <= '0;
                r_op_mis <= 1'b0;
                r_uni    <= '0;
                r_len    <= '0;
            end else begin
                r_count  <= n_count;
                r_id_mis <= n_id_mis;
                r_op_low <= n_op_low;
                r_op_mis <= n_op_mis;
                r_uni    <= n_uni;
                r_len    <= n_len;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept && (has || i_last_byte)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (has || i_last_byte)) begin
            r_has     <= has;
            r_data    <= has ? i_in_byte : 8'h00;
            r_idx     <= has ? pay_idx[8:0] : 9'd0;
            r_done    <= i_last_byte;
            r_status  <= i_last_byte ? info.status : adx_pkg::ST_OK;
            r_out_uni <= i_last_byte ? info.universe : 15'd0;
            r_out_len <= i_last_byte ? info.length : 16'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_has_byte    = r_has;
    assign o_data_byte   = r_data;
    assign o_byte_index  = r_idx;
    assign o_packet_done = r_done;
    assign o_status      = r_status;
    assign o_universe    = r_out_uni;
    assign o_length      = r_out_len;

endmodule

`default_nettype wire
